// ===== sv/chacha_pkg.sv =====
// Shared types and constants for the ChaCha keystream block.
package chacha_pkg;

  typedef logic [31:0] word_t;
  typedef logic [3:0][31:0] lane_vec_t;
  typedef logic [15:0][31:0] state_vec_t;

  localparam word_t C0     = 32'h61707865;
  localparam word_t C1_256 = 32'h3320646e;
  localparam word_t C2_256 = 32'h79622d32;
  localparam word_t C1_128 = 32'h3120646e;
  localparam word_t C2_128 = 32'h79622d36;
  localparam word_t C3     = 32'h6b206574;

  typedef enum logic [1:0] {
    ROT_16,
    ROT_12,
    ROT_8,
    ROT_7
  } rot_t;

  typedef struct packed {
    logic       start;
    logic [5:0] double_rounds;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  typedef struct packed {
    logic [63:0] data_word;
    logic        keystream_only;
    logic        restart_stream;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic        block_last;
  } out_beat_t;

endpackage

// ===== sv/chacha_qr_unit.sv =====
// Four-lane quarter-round step: add, then xor and rotate.
module chacha_qr_unit (
  input  chacha_pkg::lane_vec_t p,
  input  chacha_pkg::lane_vec_t q,
  input  chacha_pkg::lane_vec_t s,
  input  chacha_pkg::rot_t      rot,
  output chacha_pkg::lane_vec_t add_out,
  output chacha_pkg::lane_vec_t mix_out
);
  import chacha_pkg::*;

  lane_vec_t xr;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      add_out[i] = p[i] + q[i];
      xr[i] = s[i] ^ add_out[i];
      case (rot)
        ROT_16:  mix_out[i] = {xr[i][15:0], xr[i][31:16]};
        ROT_12:  mix_out[i] = {xr[i][19:0], xr[i][31:20]};
        ROT_8:   mix_out[i] = {xr[i][23:0], xr[i][31:24]};
        default: mix_out[i] = {xr[i][24:0], xr[i][31:25]};
      endcase
    end
  end

endmodule

// ===== sv/chacha_core.sv =====
// Round sequencer: working state, step counters and final add-back.
module chacha_core (
  input  logic                   clk,
  input  logic                   rst,
  input  chacha_pkg::core_ctrl_t ctrl,
  input  chacha_pkg::state_vec_t in_state,
  output chacha_pkg::core_stat_t stat,
  output chacha_pkg::state_vec_t block
);
  import chacha_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_ADD
  } core_state_t;

  core_state_t state;
  state_vec_t  x;
  state_vec_t  x_next;
  logic [5:0]  dr_left;
  logic        half;
  logic [1:0]  step;
  logic [1:0]  add_idx;
  logic        done;

  logic [3:0][3:0] ia, ib, ic, id;
  logic [3:0][3:0] pi, qi, si;
  lane_vec_t       p_vec, q_vec, s_vec, add_out, mix_out;
  rot_t            rot;

  // lane index pattern: columns when half is 0, diagonals when 1
  always_comb begin
    rot = ROT_16;
    for (int i = 0; i < 4; i++) begin
      ia[i] = {2'b00, 2'(i)};
      ib[i] = {2'b01, 2'(i) + {1'b0, half}};
      ic[i] = {2'b10, 2'(i) + {half, 1'b0}};
      id[i] = {2'b11, 2'(i) + {half, half}};
      if (state == S_ADD) begin
        pi[i] = {add_idx, 2'(i)};
        qi[i] = pi[i];
        si[i] = pi[i];
      end else begin
        case (step)
          2'd0: begin pi[i] = ia[i]; qi[i] = ib[i]; si[i] = id[i]; rot = ROT_16; end
          2'd1: begin pi[i] = ic[i]; qi[i] = id[i]; si[i] = ib[i]; rot = ROT_12; end
          2'd2: begin pi[i] = ia[i]; qi[i] = ib[i]; si[i] = id[i]; rot = ROT_8; end
          default: begin pi[i] = ic[i]; qi[i] = id[i]; si[i] = ib[i]; rot = ROT_7; end
        endcase
      end
      p_vec[i] = x[pi[i]];
      q_vec[i] = (state == S_ADD) ? in_state[qi[i]] : x[qi[i]];
      s_vec[i] = x[si[i]];
    end
  end

  chacha_qr_unit u_qr (
    .p       (p_vec),
    .q       (q_vec),
    .s       (s_vec),
    .rot     (rot),
    .add_out (add_out),
    .mix_out (mix_out)
  );

  always_comb begin
    x_next = x;
    for (int i = 0; i < 4; i++) begin
      x_next[pi[i]] = add_out[i];
      if (state == S_ROUND) x_next[si[i]] = mix_out[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      dr_left <= '0;
      half    <= 1'b0;
      step    <= '0;
      add_idx <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            x       <= in_state;
            dr_left <= ctrl.double_rounds;
            half    <= 1'b0;
            step    <= '0;
            add_idx <= '0;
            state   <= (ctrl.double_rounds == '0) ? S_ADD : S_ROUND;
          end
        end
        S_ROUND: begin
          x    <= x_next;
          step <= step + 2'd1;
          if (step == 2'd3) begin
            half <= ~half;
            if (half) begin
              dr_left <= dr_left - 6'd1;
              if (dr_left == 6'd1) state <= S_ADD;
            end
          end
        end
        S_ADD: begin
          x       <= x_next;
          add_idx <= add_idx + 2'd1;
          if (add_idx == 2'd3) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != S_IDLE);
  assign stat.done = done;
  assign block     = x;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == S_IDLE)
    else $error("done raised outside idle");
  a_round_left: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> dr_left != '0)
    else $error("round state with no double rounds left");
  a_done_from_add: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> $past(state == S_ADD && add_idx == 2'd3))
    else $error("done without final add-back step");

endmodule

// ===== sv/chacha_stream_cipher.sv =====
// Top level: configuration registers, stream position and beat handshakes.
// Latency: a taken beat goes through the emit state into the output register, which waits
//   while the output is stalled; a beat at block position 0 first runs generation.
// Throughput: one beat at a time; block generation is paced by the single four-lane
//   quarter-round step unit.
// Reset (rst, synchronous): counter, position and handshakes clear, registers
//   return to their defaults; no clearing pass.
module chacha_stream_cipher (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  chacha_pkg::in_beat_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output chacha_pkg::out_beat_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data
);
  import chacha_pkg::*;

  typedef enum logic [2:0] {
    REG_KEY_01   = 3'd0,
    REG_KEY_23   = 3'd1,
    REG_KEY_45   = 3'd2,
    REG_KEY_67   = 3'd3,
    REG_KEY_256  = 3'd4,
    REG_NONCE    = 3'd5,
    REG_ROUNDS   = 3'd6,
    REG_UNUSED   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_START,
    T_GEN,
    T_EMIT
  } top_state_t;

  // configuration
  logic [63:0] key_words_0_1, key_words_2_3, key_words_4_5, key_words_6_7;
  logic        key_is_256;
  logic [63:0] nonce_value;
  logic [5:0]  round_count;

  // stream state and held beat
  top_state_t  state;
  logic [63:0] block_counter;
  logic [2:0]  word_position;
  logic [63:0] hold_data;
  logic        hold_ks_only;

  core_ctrl_t  core_ctrl;
  core_stat_t  core_stat;
  state_vec_t  in_state;
  state_vec_t  block;
  logic [63:0] hi0, hi1, ks;
  logic [6:0]  rounds_up;
  logic        in_take, out_free;

  assign cfg_ready = (state == T_IDLE);

  // writes land only while idle, so generation sees stable values
  always_ff @(posedge clk) begin
    if (rst) begin
      key_words_0_1 <= '0;
      key_words_2_3 <= '0;
      key_words_4_5 <= '0;
      key_words_6_7 <= '0;
      key_is_256    <= 1'b1;
      nonce_value   <= '0;
      round_count   <= 6'd20;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY_01:  key_words_0_1 <= cfg_data;
        REG_KEY_23:  key_words_2_3 <= cfg_data;
        REG_KEY_45:  key_words_4_5 <= cfg_data;
        REG_KEY_67:  key_words_6_7 <= cfg_data;
        REG_KEY_256: key_is_256    <= cfg_data[0];
        REG_NONCE:   nonce_value   <= cfg_data;
        REG_ROUNDS:  round_count   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // block input: constants, key (128-bit key used twice), counter, nonce
  always_comb begin
    hi0 = key_is_256 ? key_words_4_5 : key_words_0_1;
    hi1 = key_is_256 ? key_words_6_7 : key_words_2_3;
    in_state[0]  = C0;
    in_state[1]  = key_is_256 ? C1_256 : C1_128;
    in_state[2]  = key_is_256 ? C2_256 : C2_128;
    in_state[3]  = C3;
    in_state[4]  = key_words_0_1[31:0];
    in_state[5]  = key_words_0_1[63:32];
    in_state[6]  = key_words_2_3[31:0];
    in_state[7]  = key_words_2_3[63:32];
    in_state[8]  = hi0[31:0];
    in_state[9]  = hi0[63:32];
    in_state[10] = hi1[31:0];
    in_state[11] = hi1[63:32];
    in_state[12] = block_counter[31:0];
    in_state[13] = block_counter[63:32];
    in_state[14] = nonce_value[31:0];
    in_state[15] = nonce_value[63:32];
  end

  // odd round counts run as the next even count
  assign rounds_up = {1'b0, round_count} + 7'd1;
  assign core_ctrl.start         = (state == T_START);
  assign core_ctrl.double_rounds = rounds_up[6:1];

  chacha_core u_core (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (core_ctrl),
    .in_state (in_state),
    .stat     (core_stat),
    .block    (block)
  );

  // one 64-bit keystream word per position
  assign ks = {block[{word_position, 1'b1}], block[{word_position, 1'b0}]};

  assign in_stall = (state != T_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      block_counter <= '0;
      word_position <= '0;
      out_valid     <= 1'b0;
    end else begin
      // output register loads in emit, otherwise empties when taken
      if (state == T_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (in_take) begin
            hold_data    <= in_data.data_word;
            hold_ks_only <= in_data.keystream_only;
            if (in_data.restart_stream) begin
              block_counter <= '0;
              word_position <= '0;
            end
            // a fresh block is needed at position zero
            state <= (in_data.restart_stream || word_position == '0) ? T_START : T_EMIT;
          end
        end
        T_START: state <= T_GEN;
        T_GEN: begin
          if (core_stat.done) state <= T_EMIT;
        end
        T_EMIT: begin
          // output register frees up, or is taken this edge
          if (out_free) begin
            out_data.out_word   <= hold_ks_only ? ks : (hold_data ^ ks);
            out_data.block_last <= (word_position == 3'd7);
            word_position       <= word_position + 3'd1;
            if (word_position == 3'd7) block_counter <= block_counter + 64'd1;
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  a_start_core_idle: assert property (@(posedge clk) disable iff (rst)
    core_ctrl.start |-> !core_stat.busy)
    else $error("generation started while core busy");
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == T_EMIT))
    else $error("output beat raised outside emit");
  a_done_in_gen: assert property (@(posedge clk) disable iff (rst)
    core_stat.done |-> state == T_GEN)
    else $error("core finished while not awaited");

endmodule

// ===== tb/sv/chacha_tb_pkg.sv =====
// Register names and the keystream scoreboard for the ChaCha stream cipher bench.
package chacha_tb_pkg;
  import chacha_pkg::*;

  typedef enum logic [2:0] {
    KEY_WORDS_0_1,
    KEY_WORDS_2_3,
    KEY_WORDS_4_5,
    KEY_WORDS_6_7,
    KEY_IS_256,
    NONCE_VALUE,
    ROUND_COUNT,
    REG_UNMAPPED
  } cfg_reg_t;

  class cipher_scoreboard;
    // shadow registers
    logic [63:0] key01, key23, key45, key67, nonce;
    logic        wide_key;
    logic [5:0]  rounds;
    // stream state
    word_t       mix[16];
    word_t       blk[16];
    logic [63:0] block_ctr;
    logic [2:0]  word_pos;
    out_beat_t   expected_beats[$];
    int          mismatches;

    function new();
      key01 = '0;
      key23 = '0;
      key45 = '0;
      key67 = '0;
      nonce = '0;
      wide_key = 1'b1;
      rounds = 6'd20;
      block_ctr = '0;
      word_pos = '0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [63:0] v);
      case (idx)
        KEY_WORDS_0_1: key01 = v;
        KEY_WORDS_2_3: key23 = v;
        KEY_WORDS_4_5: key45 = v;
        KEY_WORDS_6_7: key67 = v;
        KEY_IS_256:    wide_key = v[0];
        NONCE_VALUE:   nonce = v;
        ROUND_COUNT:   rounds = v[5:0];
        default: ;
      endcase
    endfunction

    function word_t rotl(word_t v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void qr(int a, int b, int c, int d);
      mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
      mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
      mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
      mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
    endfunction

    // Advance the stream by one accepted beat and queue the word it must produce.
    function void accept_beat(in_beat_t b);
      word_t       seed[16];
      logic [63:0] upper0, upper1, ks;
      out_beat_t   want;
      if (b.restart_stream) begin
        block_ctr = '0;
        word_pos = '0;
      end
      if (word_pos == 3'd0) begin
        upper0 = wide_key ? key45 : key01;
        upper1 = wide_key ? key67 : key23;
        seed[0] = C0;
        seed[1] = wide_key ? C1_256 : C1_128;
        seed[2] = wide_key ? C2_256 : C2_128;
        seed[3] = C3;
        seed[4] = key01[31:0];      seed[5] = key01[63:32];
        seed[6] = key23[31:0];      seed[7] = key23[63:32];
        seed[8] = upper0[31:0];     seed[9] = upper0[63:32];
        seed[10] = upper1[31:0];    seed[11] = upper1[63:32];
        seed[12] = block_ctr[31:0]; seed[13] = block_ctr[63:32];
        seed[14] = nonce[31:0];     seed[15] = nonce[63:32];
        for (int i = 0; i < 16; i++) mix[i] = seed[i];
        // odd counts run one extra round: a whole double round each pass
        for (int r = 0; r < int'(rounds); r += 2) begin
          qr(0, 4, 8, 12);
          qr(1, 5, 9, 13);
          qr(2, 6, 10, 14);
          qr(3, 7, 11, 15);
          qr(0, 5, 10, 15);
          qr(1, 6, 11, 12);
          qr(2, 7, 8, 13);
          qr(3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) blk[i] = mix[i] + seed[i];
      end
      ks = {blk[2 * word_pos + 1], blk[2 * word_pos]};
      want.out_word = b.keystream_only ? ks : (b.data_word ^ ks);
      want.block_last = (word_pos == 3'd7);
      if (word_pos == 3'd7) block_ctr = block_ctr + 64'd1;
      word_pos = word_pos + 3'd1;
      expected_beats.push_back(want);
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (expected_beats.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected output beat: out_word %h block_last %b",
                   got.out_word, got.block_last);
        mismatches++;
        return;
      end
      want = expected_beats.pop_front();
      if (got.out_word !== want.out_word || got.block_last !== want.block_last) begin
        if (mismatches < 10)
          $display("beat mismatch: out_word exp %h got %h, block_last exp %b got %b",
                   want.out_word, got.out_word, want.block_last, got.block_last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_chacha_stream_cipher.sv =====
// Top-level bench for chacha_stream_cipher: directed and random beats, scored per beat.
module tb_chacha_stream_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  import chacha_pkg::*;
  import chacha_tb_pkg::*;

  // Longest run of cycles with no handshake at all before we call it hung.
  // Worst legit case: a full HOLD_CYCLES receiver hold plus a 63-round generation.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  cipher_scoreboard sb = new();

  // Idle/stall odds in percent, set per phase by the stimulus thread.
  int idle_pct  = 0;
  int stall_pct = 0;

  // Long receiver hold: stimulus flips hold_tog, receiver counts the hold itself.
  logic hold_tog  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  int quiet_cycles = 0;

  chacha_stream_cipher DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random stall, or a solid hold when one was requested.
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  // Output monitor: every accepted result beat is scored in order.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_beat(out_data);
  end

  // Watchdog: counts cycles with no handshake on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one beat, with a random gap first; valid stays up for the next beat.
  task automatic push_beat(logic [63:0] data, logic ks_only, logic restart);
    in_beat_t b;
    b.data_word = data;
    b.keystream_only = ks_only;
    b.restart_stream = restart;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.accept_beat(b);
  endtask

  // Drop valid and wait until every expected beat has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One register write; caller lowers cfg_valid after the last of a group.
  task automatic cfg_write(cfg_reg_t idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  function automatic logic [63:0] pick64();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // New random settings; each register is touched with good odds.
  task automatic random_settings();
    logic [63:0] v;
    logic [5:0]  r;
    if ($urandom_range(9) < 7) cfg_write(KEY_WORDS_0_1, pick64());
    if ($urandom_range(9) < 7) cfg_write(KEY_WORDS_2_3, pick64());
    if ($urandom_range(9) < 7) cfg_write(KEY_WORDS_4_5, pick64());
    if ($urandom_range(9) < 7) cfg_write(KEY_WORDS_6_7, pick64());
    if ($urandom_range(9) < 7) begin
      v = ($urandom_range(3) == 0) ? pick64() : 64'($urandom_range(1));
      cfg_write(KEY_IS_256, v);
    end
    if ($urandom_range(9) < 7) cfg_write(NONCE_VALUE, pick64());
    if ($urandom_range(9) < 8) begin
      // mostly short round counts to keep the run quick; a few big ones
      case ($urandom_range(19))
        12, 13, 14, 15: r = 6'd20;
        16, 17:         r = 6'($urandom_range(21, 40));
        18:             r = 6'($urandom_range(41, 63));
        default:        r = 6'($urandom_range(12));
      endcase
      v = ($urandom_range(3) == 0) ? pick64() : '0;
      v[5:0] = r;
      cfg_write(ROUND_COUNT, v);
    end
    if ($urandom_range(9) == 0) cfg_write(REG_UNMAPPED, pick64());
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int idle_mix[4];
    int stall_mix[4];
    int seg_len;
    idle_mix  = '{0, 46, 0, 16};
    stall_mix = '{0, 0, 46, 16};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings (256-bit zero key, 20 rounds), data extremes,
    // a keystream-only beat and a restart in the middle of a block.
    push_beat('0, 1'b0, 1'b0);
    push_beat('1, 1'b0, 1'b0);
    push_beat({$urandom, $urandom}, 1'b1, 1'b0);
    push_beat(64'ha5a5_5a5a_a5a5_5a5a, 1'b0, 1'b0);
    push_beat({$urandom, $urandom}, 1'b0, 1'b1);
    push_beat({$urandom, $urandom}, 1'b1, 1'b0);

    // Mid-block rewrite: 128-bit all-ones key, zero rounds. The rest of the
    // current block must still use the old keystream.
    settle();
    cfg_write(KEY_WORDS_0_1, '1);
    cfg_write(KEY_WORDS_2_3, '1);
    cfg_write(KEY_IS_256, 64'hffff_ffff_ffff_fffe);
    cfg_write(ROUND_COUNT, '0);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 8; i++) push_beat({$urandom, $urandom}, i == 5, 1'b0);

    // Round count above 32 (upper data bits set), unmapped index ignored.
    settle();
    cfg_write(NONCE_VALUE, '1);
    cfg_write(KEY_WORDS_4_5, '1);
    cfg_write(KEY_WORDS_6_7, {$urandom, $urandom});
    cfg_write(KEY_IS_256, '1);
    cfg_write(ROUND_COUNT, '1);
    cfg_write(REG_UNMAPPED, '0);
    cfg_valid <= 1'b0;
    push_beat({$urandom, $urandom}, 1'b0, 1'b1);
    push_beat('1, 1'b0, 1'b0);
    push_beat({$urandom, $urandom}, 1'b1, 1'b0);

    // Odd count (one round runs as two), then a round count of 32.
    settle();
    cfg_write(ROUND_COUNT, 64'd1);
    cfg_write(KEY_WORDS_0_1, '0);
    cfg_valid <= 1'b0;
    push_beat('0, 1'b1, 1'b1);
    push_beat({$urandom, $urandom}, 1'b0, 1'b0);
    settle();
    cfg_write(ROUND_COUNT, 64'd32);
    cfg_valid <= 1'b0;
    push_beat({$urandom, $urandom}, 1'b0, 1'b1);

    // Random: four idling phases, five segments each, new settings between
    // segments. Settling before each rewrite doubles as the sender pause.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_mix[ph];
      stall_pct = stall_mix[ph];
      for (int seg = 0; seg < 5; seg++) begin
        settle();
        random_settings();
        // one long receiver hold while the sender keeps offering beats
        if (ph == 0 && seg == 2) hold_tog <= ~hold_tog;
        seg_len = $urandom_range(30, 55);
        for (int n = 0; n < seg_len; n++) begin
          push_beat({$urandom, $urandom}, $urandom_range(99) < 20,
                    (n == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 4));
        end
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== chacha_stream_cipher.f =====
sv/chacha_pkg.sv
sv/chacha_qr_unit.sv
sv/chacha_core.sv
sv/chacha_stream_cipher.sv
tb/sv/chacha_tb_pkg.sv
tb/sv/tb_chacha_stream_cipher.sv
